// ===== rtl/core/lup_linear_system_solver_defines.svh =====
// assertion macros for the solver
`ifndef LUP_LINEAR_SYSTEM_SOLVER_DEFINES_SVH
`define LUP_LINEAR_SYSTEM_SOLVER_DEFINES_SVH
`define LUP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define LUP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/lup_pkg.sv =====
package lup_pkg;
    typedef struct packed {
        logic [2:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic               last;
    } lup_in_t;
    typedef struct packed {
        logic [2:0]         index;
        logic signed [31:0] solution;
        logic               singular;
        logic               final_res;
    } lup_out_t;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
    // saturate a wide value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) r = SAT_MAX;
        else if (v < -72'sd2147483648) r = SAT_MIN;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// ===== rtl/core/lup_ram.sv =====
module lup_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/lup_div.sv =====
// signed fixed-point divider, one quotient bit per cycle
module lup_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    import lup_pkg::*;
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] n_reg, n_next;
    logic [NW:0]   rem_reg, rem_next;
    logic [31:0]   d_reg, d_next;
    logic          neg_reg, neg_next, busy_reg, busy_next, dz_reg, dz_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW:0]   trial;
    logic signed [NW+1:0] sq;
    assign trial = {rem_reg[NW-1:0], n_reg[NW-1]} - {{(NW-31){1'b0}}, d_reg};
    always_comb begin
        n_next = n_reg; rem_next = rem_reg; d_next = d_reg; neg_next = neg_reg;
        busy_next = busy_reg; cnt_next = cnt_reg; dz_next = dz_reg;
        if (start) begin
            n_next = {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
            d_next = den[31] ? 32'(-den) : 32'(den);
            neg_next = num[31] ^ den[31];
            dz_next = (den == 32'sd0);
            rem_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[NW]) rem_next = trial;
            else rem_next = {rem_reg[NW-1:0], n_reg[NW-1]};
            n_next = {n_reg[NW-2:0], ~trial[NW]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        n_reg <= n_next; rem_reg <= rem_next; d_reg <= d_next;
        neg_reg <= neg_next; dz_reg <= dz_next;
    end
    assign done = busy_reg && cnt_reg == CW'(1);
    // sign and saturate the quotient taken from the shift register's next value
    always_comb begin
        sq = neg_reg ? -$signed({2'b00, n_next}) : $signed({2'b00, n_next});
        quo = dz_reg ? 32'sd0 : sat32(72'(sq));
    end
endmodule

// ===== rtl/core/lup_linear_system_solver.sv =====
// Solver for A x = b, A of N by N in signed Q16.16 with FRAC_BITS fraction
// bits. Entries of [A|b] load one word a cycle (column N is b); the word marked
// last starts LU decomposition with partial pivoting, forward and back
// substitution, then N solution words leave in index order. Solving takes on
// the order of N^3/3 multiply steps (one RAM read port feeding one multiplier)
// plus N*(N+1)/2 divides on the bit-serial divider; input is not ready
// meanwhile. A zero pivot gives zero results flagged singular.
module lup_linear_system_solver #(
    parameter int N = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lup_pkg::lup_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lup_pkg::lup_out_t m_data
);
    import lup_pkg::*;
    `include "lup_linear_system_solver_defines.svh"
    localparam int COLS = N + 1;
    localparam int IW = $clog2(N);
    localparam int JW = $clog2(N + 1);
    localparam int MD = N * COLS;
    localparam int WD = N * N;
    localparam int MAW = $clog2(MD);
    localparam int WAW = $clog2(WD);

    localparam logic [4:0] S_LOAD = 5'd0, S_COPY = 5'd1, S_PIVR = 5'd2,
        S_PIVW = 5'd3, S_SWR = 5'd4, S_SWW = 5'd5, S_SWW2 = 5'd6,
        S_DIVR = 5'd7, S_DIVW = 5'd8, S_DIVS = 5'd9, S_UPR = 5'd10,
        S_UPW = 5'd11, S_UPW2 = 5'd12, S_FWB = 5'd13, S_FWR = 5'd14,
        S_FWW = 5'd15, S_FWE = 5'd16, S_BKR = 5'd17, S_BKW = 5'd18,
        S_BKE = 5'd19, S_BKD = 5'd20, S_OUT = 5'd21, S_WAIT = 5'd22,
        S_NEXT = 5'd23, S_BKS = 5'd24, S_FWS = 5'd25;

    logic [4:0]  st_reg, st_next;
    logic [IW-1:0] i_reg, i_next, k_reg, k_next, piv_reg, piv_next;
    logic [JW-1:0] j_reg, j_next;
    logic [31:0] best_reg, best_next;
    logic [31:0] hold_reg, hold_next, piv_val_reg, piv_val_next;
    logic signed [71:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic        sing_reg, sing_next, pv_reg, pv_next;
    logic [IW-1:0] perm_reg [N];
    logic [IW-1:0] perm_next [N];
    logic [31:0] vec_reg [N];
    logic [31:0] vec_next [N];
    logic        m_valid_reg, m_valid_next;
    lup_out_t    m_data_reg, m_data_next;

    // matrix store and working copy
    logic mwe, wwe;
    logic [MAW-1:0] mwa, mra;
    logic [WAW-1:0] wwa, wra;
    logic [31:0] mrd, wrd, wwd;
    logic signed [31:0] mul_a, mul_b;
    logic div_start, div_done;
    logic signed [31:0] div_num, div_den, div_quo;

    lup_ram #(.WIDTH(32), .DEPTH(MD)) u_mstore (.aclk(aclk), .we(mwe), .waddr(mwa),
        .wdata(s_data.value), .raddr(mra), .rdata(mrd));
    lup_ram #(.WIDTH(32), .DEPTH(WD)) u_wstore (.aclk(aclk), .we(wwe), .waddr(wwa),
        .wdata(wwd), .raddr(wra), .rdata(wrd));
    lup_div #(.FRAC_BITS(FRAC_BITS)) u_div (.aclk(aclk), .aresetn(aresetn),
        .start(div_start), .num(div_num), .den(div_den), .done(div_done),
        .quo(div_quo));

    function automatic logic [WAW-1:0] wa(input logic [IW-1:0] r, input logic [JW-1:0] c);
        return WAW'(r * N + c);
    endfunction
    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    // floored product: arithmetic shift of the exact product
    logic signed [63:0] fprod;
    assign fprod = prod_reg >>> FRAC_BITS;
    always_ff @(posedge aclk) prod_reg <= mul_a * mul_b;

    assign s_ready = (st_reg == S_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // sequencer
    always_comb begin
        st_next = st_reg; i_next = i_reg; j_next = j_reg; k_next = k_reg;
        piv_next = piv_reg; best_next = best_reg; hold_next = hold_reg;
        piv_val_next = piv_val_reg; acc_next = acc_reg; sing_next = sing_reg;
        pv_next = pv_reg; perm_next = perm_reg; vec_next = vec_reg;
        m_valid_next = m_valid_reg; m_data_next = m_data_reg;
        mwe = 1'b0; mwa = MAW'(s_data.row * COLS + s_data.col); mra = '0;
        wwe = 1'b0; wwa = '0; wwd = wrd; wra = '0;
        mul_a = 32'sd0; mul_b = 32'sd0;
        div_start = 1'b0; div_num = $signed(wrd); div_den = $signed(piv_val_reg);
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (st_reg)
            S_LOAD: begin
                if (s_valid) begin
                    mwe = (32'(s_data.row) < N) && (32'(s_data.col) <= N);
                    if (s_data.last) begin
                        st_next = S_COPY; i_next = '0; j_next = '0; pv_next = 1'b0;
                        sing_next = 1'b0;
                        for (int q = 0; q < N; q++) perm_next[q] = IW'(q);
                    end
                end
            end
            // copy A into the working store, each read issued the cycle before its write
            S_COPY: begin
                mra = MAW'(i_reg * COLS + j_reg);
                wwe = pv_reg; wwa = wa(piv_reg, JW'(k_reg)); wwd = mrd;
                piv_next = i_reg; k_next = IW'(j_reg); pv_next = 1'b1;
                if (pv_reg && piv_reg == IW'(N - 1) && k_reg == IW'(N - 1)) begin
                    st_next = S_PIVR; k_next = '0; i_next = '0; pv_next = 1'b0;
                    best_next = '0;
                end else if (j_reg == JW'(N - 1)) begin
                    j_next = '0;
                    if (i_reg != IW'(N - 1)) i_next = i_reg + 1'b1;
                end else j_next = j_reg + 1'b1;
            end
            // pivot search over column k
            S_PIVR: begin
                if (!pv_reg) begin
                    i_next = k_reg; piv_next = k_reg; best_next = '0; pv_next = 1'b1;
                    wra = wa(k_reg, JW'(k_reg));
                end else begin
                    if (mag(wrd) > best_reg) begin best_next = mag(wrd); piv_next = i_reg; end
                    if (i_reg == IW'(N - 1)) st_next = S_PIVW;
                    else begin
                        i_next = i_reg + 1'b1;
                        wra = wa(i_reg + 1'b1, JW'(k_reg));
                    end
                end
            end
            S_PIVW: begin
                pv_next = 1'b0;
                if (best_reg == '0) begin
                    sing_next = 1'b1; st_next = S_OUT; i_next = '0;
                end else if (piv_reg != k_reg) begin
                    perm_next[k_reg] = perm_reg[piv_reg];
                    perm_next[piv_reg] = perm_reg[k_reg];
                    j_next = '0; st_next = S_SWR;
                end else begin
                    st_next = S_DIVS; wra = wa(k_reg, JW'(k_reg));
                end
            end
            // swap rows k and piv, one column at a time
            S_SWR: begin wra = wa(k_reg, j_reg); st_next = S_SWW; end
            S_SWW: begin
                hold_next = wrd; wra = wa(piv_reg, j_reg); st_next = S_SWW2;
            end
            S_SWW2: begin
                wwe = 1'b1; wwa = wa(k_reg, j_reg); wwd = wrd; st_next = S_NEXT;
            end
            S_NEXT: begin
                wwe = 1'b1; wwa = wa(piv_reg, j_reg); wwd = hold_reg;
                if (j_reg == JW'(N - 1)) begin
                    st_next = S_DIVS; wra = wa(k_reg, JW'(k_reg));
                end else begin j_next = j_reg + 1'b1; st_next = S_SWR; end
            end
            S_DIVS: begin
                piv_val_next = wrd;
                if (k_reg == IW'(N - 1)) begin st_next = S_FWB; i_next = '0; end
                else begin i_next = k_reg + 1'b1; st_next = S_DIVR; end
            end
            // l[i][k] = w[i][k] / pivot
            S_DIVR: begin wra = wa(i_reg, JW'(k_reg)); st_next = S_DIVW; pv_next = 1'b0; end
            S_DIVW: begin
                if (!pv_reg) begin div_start = 1'b1; pv_next = 1'b1; end
                else if (div_done) begin
                    wwe = 1'b1; wwa = wa(i_reg, JW'(k_reg)); wwd = div_quo;
                    hold_next = div_quo; j_next = JW'(k_reg) + 1'b1; st_next = S_UPR;
                end
            end
            // w[i][j] -= l * w[k][j]
            S_UPR: begin wra = wa(k_reg, j_reg); st_next = S_UPW; end
            S_UPW: begin
                mul_a = $signed(hold_reg); mul_b = $signed(wrd);
                wra = wa(i_reg, j_reg); st_next = S_UPW2;
            end
            S_UPW2: begin
                wwe = 1'b1; wwa = wa(i_reg, j_reg);
                wwd = sat32(72'($signed(wrd)) - 72'(fprod));
                if (j_reg != JW'(N - 1)) begin j_next = j_reg + 1'b1; st_next = S_UPR; end
                else if (i_reg != IW'(N - 1)) begin i_next = i_reg + 1'b1; st_next = S_DIVR; end
                else begin k_next = k_reg + 1'b1; st_next = S_PIVR; pv_next = 1'b0; end
            end
            // forward substitution
            S_FWB: begin acc_next = '0; j_next = '0; st_next = (i_reg == '0) ? S_FWE : S_FWR; end
            S_FWR: begin wra = wa(i_reg, j_reg); st_next = S_FWW; end
            S_FWW: begin
                mul_a = $signed(wrd); mul_b = $signed(vec_reg[IW'(j_reg)]); st_next = S_FWS;
            end
            S_FWS: begin
                acc_next = acc_reg + 72'(fprod);
                if (j_reg + 1'b1 == JW'(i_reg)) st_next = S_FWE;
                else begin j_next = j_reg + 1'b1; st_next = S_FWR; end
            end
            S_FWE: begin
                mra = MAW'(perm_reg[i_reg] * COLS + N);
                if (pv_reg) begin
                    vec_next[i_reg] = sat32(72'($signed(mrd)) - acc_reg);
                    pv_next = 1'b0;
                    if (i_reg == IW'(N - 1)) begin st_next = S_BKS; end
                    else begin i_next = i_reg + 1'b1; st_next = S_FWB; end
                end else pv_next = 1'b1;
            end
            // back substitution from the last row up
            S_BKS: begin
                acc_next = '0; j_next = JW'(i_reg) + 1'b1;
                st_next = (i_reg == IW'(N - 1)) ? S_BKE : S_BKR;
            end
            S_BKR: begin wra = wa(i_reg, j_reg); st_next = S_BKW; end
            S_BKW: begin
                mul_a = $signed(wrd); mul_b = $signed(vec_reg[IW'(j_reg)]); st_next = S_BKD;
            end
            S_BKD: begin
                acc_next = acc_reg + 72'(fprod);
                if (j_reg == JW'(N - 1)) st_next = S_BKE;
                else begin j_next = j_reg + 1'b1; st_next = S_BKR; end
            end
            S_BKE: begin
                wra = wa(i_reg, JW'(i_reg));
                if (!pv_reg) pv_next = 1'b1;
                else begin
                    div_num = sat32(72'($signed(vec_reg[i_reg])) - acc_reg);
                    div_den = $signed(wrd);
                    div_start = 1'b1; pv_next = 1'b0; st_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (div_done) begin
                    vec_next[i_reg] = div_quo;
                    if (i_reg == '0) st_next = S_OUT;
                    else begin i_next = i_reg - 1'b1; st_next = S_BKS; end
                end
            end
            // emit solution words
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.index = 3'(i_reg);
                    m_data_next.solution = sing_reg ? 32'sd0 : $signed(vec_reg[i_reg]);
                    m_data_next.singular = sing_reg;
                    m_data_next.final_res = (i_reg == IW'(N - 1));
                    if (i_reg == IW'(N - 1)) st_next = S_LOAD;
                    else i_next = i_reg + 1'b1;
                end
            end
            default: st_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_LOAD;
            m_valid_reg <= 1'b0;
            pv_reg <= 1'b0;
            sing_reg <= 1'b0;
            for (int q = 0; q < N; q++) perm_reg[q] <= IW'(q);
        end else begin
            st_reg <= st_next;
            m_valid_reg <= m_valid_next;
            pv_reg <= pv_next;
            sing_reg <= sing_next;
            perm_reg <= perm_next;
        end
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; piv_reg <= piv_next;
        best_reg <= best_next; hold_reg <= hold_next; piv_val_reg <= piv_val_next;
        acc_reg <= acc_next; vec_reg <= vec_next; m_data_reg <= m_data_next;
    end

    `LUP_ASSERT_IMPL(a_ready_load, aclk, aresetn, s_ready, st_reg == S_LOAD, "ready outside load")
    `LUP_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data),
        "result dropped")
    `LUP_ASSERT_NEXT(a_last_load, aclk, aresetn, m_valid && m_ready && m_data.final_res,
        !m_valid || st_reg == S_LOAD, "extra word after final")
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lup_pkg::*;

    localparam int DIM = 8;
    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 50000;
    localparam int HOLD_CYCLES = 400;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    lup_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    lup_out_t m_data;

    lup_linear_system_solver #(.N(DIM), .FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // words waiting to be sent and solution words still to arrive
    lup_in_t  word_q[$];
    lup_out_t solution_q[$];

    // shadow of the block's stores
    longint aug[DIM][DIM+1];
    longint xvec[DIM];

    int send_idle = 14;
    int recv_idle = 88;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_left = 0;
    int errors = 0;
    int words_sent = 0;
    int solves = 0;
    int singular_seen = 0;
    int results_seen = 0;
    int quiet = 0;

    // clock and reset
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // product floored to the fraction grid
    function automatic longint fx_product(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic longint fx_quotient(longint a, longint b);
        if (b == 0) return 0;
        return clamp32((a * (64'sd1 << FRAC)) / b);
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // store one word and, on last, solve the system and queue the solution
    task automatic solve_word(lup_in_t w);
        longint lu[DIM][DIM];
        int perm[DIM];
        longint best, s, t;
        int piv, ti;
        bit sing;
        lup_out_t r;
        sing = 0;
        if (w.row < DIM && w.col <= DIM) aug[w.row][w.col] = longint'(w.value);
        if (!w.last) return;
        solves++;
        for (int i = 0; i < DIM; i++) begin
            perm[i] = i;
            for (int j = 0; j < DIM; j++) lu[i][j] = aug[i][j];
        end
        // decomposition with partial pivoting
        for (int k = 0; k < DIM && !sing; k++) begin
            best = 0;
            piv = k;
            for (int i = k; i < DIM; i++) begin
                if (magnitude(lu[i][k]) > best) begin
                    best = magnitude(lu[i][k]);
                    piv = i;
                end
            end
            if (best == 0) begin
                sing = 1;
            end else begin
                if (piv != k) begin
                    ti = perm[k]; perm[k] = perm[piv]; perm[piv] = ti;
                    for (int j = 0; j < DIM; j++) begin
                        t = lu[k][j]; lu[k][j] = lu[piv][j]; lu[piv][j] = t;
                    end
                end
                for (int i = k + 1; i < DIM; i++) begin
                    lu[i][k] = fx_quotient(lu[i][k], lu[k][k]);
                    for (int j = k + 1; j < DIM; j++)
                        lu[i][j] = clamp32(lu[i][j] - fx_product(lu[i][k], lu[k][j]));
                end
            end
        end
        if (!sing) begin
            // forward pass with unit-lower factor
            for (int i = 0; i < DIM; i++) begin
                s = 0;
                for (int j = 0; j < i; j++) s += fx_product(lu[i][j], xvec[j]);
                xvec[i] = clamp32(aug[perm[i]][DIM] - s);
            end
            // back pass with upper factor
            for (int i = DIM - 1; i >= 0; i--) begin
                s = 0;
                for (int j = i + 1; j < DIM; j++) s += fx_product(lu[i][j], xvec[j]);
                xvec[i] = fx_quotient(clamp32(xvec[i] - s), lu[i][i]);
            end
        end else begin
            singular_seen++;
        end
        for (int i = 0; i < DIM; i++) begin
            r.index = i[2:0];
            r.solution = sing ? 32'sd0 : xvec[i][31:0];
            r.singular = sing;
            r.final_res = (i == DIM - 1);
            solution_q.push_back(r);
        end
    endtask

    // driver: offer queued words, update the shadow on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                solve_word(s_data);
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_valid <= 1;
                    s_data <= word_q.pop_front();
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // monitor: random back-pressure, one long hold-off, field checks
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (solution_q.size() == 0) begin
                    $error("solution word with nothing expected");
                    errors++;
                end else begin
                    lup_out_t e;
                    e = solution_q.pop_front();
                    if (m_data.index !== e.index) begin
                        $error("index: expected %0d got %0d", e.index, m_data.index);
                        errors++;
                    end
                    if (m_data.solution !== e.solution) begin
                        $error("solution: expected %0d got %0d", e.solution,
                               m_data.solution);
                        errors++;
                    end
                    if (m_data.singular !== e.singular) begin
                        $error("singular: expected %0d got %0d", e.singular,
                               m_data.singular);
                        errors++;
                    end
                    if (m_data.final_res !== e.final_res) begin
                        $error("final_res: expected %0d got %0d", e.final_res,
                               m_data.final_res);
                        errors++;
                    end
                end
            end
            // the long hold-off starts once a solution word is waiting
            if (hold_req && !hold_done && m_valid) begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                m_ready <= 0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(524288)) - 32'sd262144;
        endcase
    endfunction

    task automatic push_word(int r, int c, logic signed [31:0] v, bit l);
        lup_in_t w;
        w.row = r[2:0];
        w.col = c[3:0];
        w.value = v;
        w.last = l;
        word_q.push_back(w);
    endtask

    // full load with a dominant diagonal, solved on the final word
    task automatic load_system();
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c <= DIM; c++)
                push_word(r, c, (r == c) ? 32'sh00080000 + $urandom_range(65535)
                                         : $signed($urandom_range(131072)) - 32'sd65536,
                          (r == DIM - 1) && (c == DIM));
    endtask

    task automatic wait_drained();
        while (word_q.size() != 0 || s_valid || solution_q.size() != 0)
            @(posedge aclk);
    endtask

    // stimulus
    initial begin
        int n, sent;
        wait (aresetn);
        load_system();
        // directed: out-of-range columns, last on an ignored word
        push_word(3, 9, 32'sh7fffffff, 0);
        push_word(7, 15, 32'sh80000000, 1);
        // directed: extreme entries
        push_word(0, DIM, 32'sh7fffffff, 0);
        push_word(7, DIM, 32'sh80000000, 0);
        push_word(5, 2, 32'sh80000000, 0);
        push_word(2, 6, 32'sh7fffffff, 0);
        push_word(6, 6, 32'sh00000001, 1);
        // directed: zero first column gives a singular system
        for (int r = 0; r < DIM; r++) push_word(r, 0, 32'sd0, r == DIM - 1);
        wait_drained();

        // sender mostly idle, receiver with one long hold-off
        send_idle = 88;
        recv_idle = 14;
        hold_req = 1;
        sent = 0;
        while (sent < 16) begin
            if (sent >= 8 && send_idle != 0) begin
                wait_drained();
                send_idle = 0;
                recv_idle = 0;
            end
            if ($urandom_range(9) == 0) begin
                // noise: a word that writes nothing
                push_word($urandom_range(7), $urandom_range(15, 9), pick_value(),
                          $urandom_range(3) == 0);
                sent++;
            end else begin
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++)
                    push_word($urandom_range(7), $urandom_range(DIM), pick_value(), 0);
                push_word($urandom_range(7), $urandom_range(DIM), pick_value(), 1);
                sent += n + 1;
            end
            while (word_q.size() > 20) @(posedge aclk);
        end
        wait_drained();
        repeat (200) @(posedge aclk);

        $display("sent %0d words over %0d solves, %0d singular", words_sent, solves,
                 singular_seen);
        $display("checked %0d solution words under varied back-pressure", results_seen);
        if (errors == 0 && solution_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
